// ===== src/crs_pkg.sv =====
// Shared types, widths and helpers for the 3x3 Cramer's rule solver.
package crs_pkg;

    localparam int unsigned Q_W       = 16;  // Q8.8 input entry
    localparam int unsigned PROD_W    = 32;  // product of two entries
    localparam int unsigned COF_W     = 33;  // 2x2 minor
    localparam int unsigned TERM_W    = 49;  // entry times minor
    localparam int unsigned DET_W     = 51;  // sum of three terms
    localparam int unsigned MAG_W     = 48;  // |det| < 2^48
    localparam int unsigned QUO_W     = 32;  // quotient bits produced
    localparam int unsigned SOL_W     = 32;  // Q16.16 result
    localparam int unsigned DIV_STEPS = QUO_W;

    typedef logic signed [Q_W-1:0]   q88_t;
    typedef q88_t [2:0][2:0]         mat_t;   // [row][col]
    typedef q88_t [2:0]              vec_t;
    typedef logic signed [DET_W-1:0] det_t;
    typedef logic [MAG_W-1:0]        mag_t;
    typedef logic signed [SOL_W-1:0] sol_t;

    // Determinant front end to divider prep
    typedef struct packed {
        logic            valid;
        det_t            d;
        det_t [2:0]      dk;
    } det_res_t;

    // One divider stage, three lanes sharing one denominator
    typedef struct packed {
        logic                   valid;
        logic                   sing;
        mag_t                   den;
        logic [2:0][MAG_W-1:0]  rem;
        logic [2:0][QUO_W-1:0]  nlo;
        logic [2:0][QUO_W-1:0]  quo;
        logic [2:0]             neg;
        logic [2:0]             ovf;
    } div_t;

    // Cyclic neighbor indexes for 3x3 cofactors
    function automatic logic [1:0] nxt1(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] nxt2(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

// ===== src/crs_if.sv =====
// Valid/ready channel interfaces for solver requests and results.
interface crs_in_if;
    import crs_pkg::*;
    logic valid;
    logic ready;
    q88_t col0_row0;
    q88_t col0_row1;
    q88_t col0_row2;
    q88_t col1_row0;
    q88_t col1_row1;
    q88_t col1_row2;
    q88_t col2_row0;
    q88_t col2_row1;
    q88_t col2_row2;
    q88_t rhs_row0;
    q88_t rhs_row1;
    q88_t rhs_row2;

    modport source (output valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
                    col1_row2, col2_row0, col2_row1, col2_row2, rhs_row0, rhs_row1,
                    rhs_row2, input ready);
    modport sink (input valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
                  col1_row2, col2_row0, col2_row1, col2_row2, rhs_row0, rhs_row1,
                  rhs_row2, output ready);
endinterface

interface crs_out_if;
    import crs_pkg::*;
    logic valid;
    logic ready;
    sol_t sol_x0;
    sol_t sol_x1;
    sol_t sol_x2;
    logic singular;

    modport source (output valid, sol_x0, sol_x1, sol_x2, singular, input ready);
    modport sink (input valid, sol_x0, sol_x1, sol_x2, singular, output ready);
endinterface

// ===== src/crs_det.sv =====
// Four-stage determinant pipeline: products, cofactors, terms, sums.
module crs_det (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  crs_pkg::mat_t      a_in,
    input  crs_pkg::vec_t      b_in,
    output crs_pkg::det_res_t  res
);
    import crs_pkg::*;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [PROD_W-1:0] p1_reg [3][3];
    logic signed [PROD_W-1:0] p2_reg [3][3];
    mat_t                     a1_reg, a2_reg;
    vec_t                     b1_reg, b2_reg;
    logic signed [COF_W-1:0]  cof_reg [3][3];
    logic signed [TERM_W-1:0] td_reg [3];
    logic signed [TERM_W-1:0] tk_reg [3][3];   // [k][r]
    det_t                     d_reg;
    det_t [2:0]               dk_reg;

    function automatic logic signed [PROD_W-1:0] mul16(input q88_t x, input q88_t y);
        return PROD_W'(x) * PROD_W'(y);
    endfunction

    function automatic logic signed [TERM_W-1:0] mulc(input q88_t x,
                                                       input logic signed [COF_W-1:0] y);
        return TERM_W'(x) * TERM_W'(y);
    endfunction

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Advance payload through the four stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    p1_reg[r][k] <= mul16(a_in[nxt1(2'(r))][nxt1(2'(k))],
                                          a_in[nxt2(2'(r))][nxt2(2'(k))]);
                    p2_reg[r][k] <= mul16(a_in[nxt1(2'(r))][nxt2(2'(k))],
                                          a_in[nxt2(2'(r))][nxt1(2'(k))]);
                    cof_reg[r][k] <= COF_W'(p1_reg[r][k]) - COF_W'(p2_reg[r][k]);
                    tk_reg[k][r]  <= mulc(b2_reg[r], cof_reg[r][k]);
                end
                td_reg[r] <= mulc(a2_reg[r][0], cof_reg[r][0]);
            end
            a1_reg <= a_in;
            b1_reg <= b_in;
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            d_reg  <= DET_W'(td_reg[0]) + DET_W'(td_reg[1]) + DET_W'(td_reg[2]);
            for (int k = 0; k < 3; k++)
            begin
                dk_reg[k] <= DET_W'(tk_reg[k][0]) + DET_W'(tk_reg[k][1])
                           + DET_W'(tk_reg[k][2]);
            end
        end
    end

    assign res.valid = v4_reg;
    assign res.d     = d_reg;
    assign res.dk    = dk_reg;

endmodule

// ===== src/crs_div_step.sv =====
// One restoring-division step for three lanes sharing a denominator.
module crs_div_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  crs_pkg::div_t d_in,
    output crs_pkg::div_t d_out
);
    import crs_pkg::*;

    logic valid_reg;
    div_t data_reg;
    div_t data_next;
    logic [MAG_W:0] trial [3];

    // Shift in one numerator bit and subtract where it fits
    always_comb
    begin
        data_next = d_in;
        for (int l = 0; l < 3; l++)
        begin
            trial[l] = {d_in.rem[l], d_in.nlo[l][QUO_W-1]};
            data_next.nlo[l] = {d_in.nlo[l][QUO_W-2:0], 1'b0};
            if (trial[l] >= {1'b0, d_in.den})
            begin
                data_next.rem[l] = MAG_W'(trial[l] - {1'b0, d_in.den});
                data_next.quo[l] = {d_in.quo[l][QUO_W-2:0], 1'b1};
            end
            else
            begin
                data_next.rem[l] = trial[l][MAG_W-1:0];
                data_next.quo[l] = {d_in.quo[l][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        d_out       = data_reg;
        d_out.valid = valid_reg;
    end

endmodule

// ===== src/cramer_3x3_linear_solver.sv =====
// Top level: pipelined 3x3 linear solver by Cramer's rule, Q8.8 in, Q16.16 out.
//
//   channel   dir  contents
//   in_ch     in   nine matrix entries (column-major) and three rhs values
//   out_ch    out  sol_x0..sol_x2 and singular flag
//   cfg       in   wr_en / wr_data: singular_threshold (48 bits)
//
// The pipeline has four determinant stages, one divider prep stage,
// 32 restoring-division stages (one quotient bit each) and the output register.
// One request is taken every cycle while the output is free or being taken.
// A stall freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and sets the threshold to 1.
module cramer_3x3_linear_solver (
    input  logic                   clk,
    input  logic                   rst_n,
    crs_in_if.sink                 in_ch,
    crs_out_if.source              out_ch,
    input  logic                   wr_en,
    input  logic [crs_pkg::MAG_W-1:0] wr_data
);
    import crs_pkg::*;

    logic     en;
    mat_t     a_in;
    vec_t     b_in;
    det_res_t det;
    mag_t     thr_reg;
    div_t     stg [DIV_STEPS+1];
    logic     prep_valid_reg;
    div_t     prep_reg;
    div_t     prep_next;
    logic     out_valid_reg;
    sol_t     sol_reg [3];
    logic     sing_reg;
    sol_t     sol_next [3];
    det_t     abs_d;
    det_t     abs_k [3];

    // Advance everything unless a finished result is held
    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    assign a_in[0][0] = in_ch.col0_row0;
    assign a_in[1][0] = in_ch.col0_row1;
    assign a_in[2][0] = in_ch.col0_row2;
    assign a_in[0][1] = in_ch.col1_row0;
    assign a_in[1][1] = in_ch.col1_row1;
    assign a_in[2][1] = in_ch.col1_row2;
    assign a_in[0][2] = in_ch.col2_row0;
    assign a_in[1][2] = in_ch.col2_row1;
    assign a_in[2][2] = in_ch.col2_row2;
    assign b_in[0]    = in_ch.rhs_row0;
    assign b_in[1]    = in_ch.rhs_row1;
    assign b_in[2]    = in_ch.rhs_row2;

    // Hold the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= MAG_W'(1);
        end
        else if (wr_en)
        begin
            thr_reg <= wr_data;
        end
    end

    crs_det u_det (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_ch.valid && in_ch.ready),
        .a_in     (a_in),
        .b_in     (b_in),
        .res      (det)
    );

    // Prepare magnitudes, signs, overflow and the singular test
    always_comb
    begin
        abs_d = det.d[DET_W-1] ? -det.d : det.d;
        prep_next       = '0;
        prep_next.valid = det.valid;
        prep_next.den   = abs_d[MAG_W-1:0];
        prep_next.sing  = (abs_d[MAG_W-1:0] == '0) || (abs_d[MAG_W-1:0] < thr_reg);
        for (int l = 0; l < 3; l++)
        begin
            abs_k[l] = det.dk[l][DET_W-1] ? -det.dk[l] : det.dk[l];
            prep_next.neg[l] = det.dk[l][DET_W-1] ^ det.d[DET_W-1];
            prep_next.ovf[l] = {16'b0, abs_k[l][MAG_W-1:0]} >= {abs_d[MAG_W-1:0], 16'b0};
            prep_next.rem[l] = MAG_W'(abs_k[l][MAG_W-1:16]);
            prep_next.nlo[l] = {abs_k[l][15:0], 16'b0};
            prep_next.quo[l] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= prep_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
        end
    end

    always_comb
    begin
        stg[0]       = prep_reg;
        stg[0].valid = prep_valid_reg;
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        crs_div_step u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d_in  (stg[i]),
            .d_out (stg[i+1])
        );
    end

    // Saturate, apply sign and zero singular results
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (stg[DIV_STEPS].sing)
            begin
                sol_next[l] = '0;
            end
            else if (stg[DIV_STEPS].neg[l])
            begin
                if (stg[DIV_STEPS].ovf[l] || (stg[DIV_STEPS].quo[l] > {1'b1, 31'b0}))
                begin
                    sol_next[l] = {1'b1, 31'b0};
                end
                else
                begin
                    sol_next[l] = -stg[DIV_STEPS].quo[l];
                end
            end
            else if (stg[DIV_STEPS].ovf[l] || stg[DIV_STEPS].quo[l][QUO_W-1])
            begin
                sol_next[l] = {1'b0, {(SOL_W-1){1'b1}}};
            end
            else
            begin
                sol_next[l] = stg[DIV_STEPS].quo[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= stg[DIV_STEPS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg <= stg[DIV_STEPS].sing;
            for (int l = 0; l < 3; l++)
            begin
                sol_reg[l] <= sol_next[l];
            end
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.sol_x0   = sol_reg[0];
    assign out_ch.sol_x1   = sol_reg[1];
    assign out_ch.sol_x2   = sol_reg[2];
    assign out_ch.singular = sing_reg;

    // A singular result carries zero solutions
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.singular |->
            out_ch.sol_x0 == '0 && out_ch.sol_x1 == '0 && out_ch.sol_x2 == '0)
        else $error("singular result with nonzero solution");

    // A non-singular request has a nonzero divisor at or above threshold
    a_den_ok: assert property (@(posedge clk) disable iff (!rst_n)
        prep_valid_reg && !prep_reg.sing |-> prep_reg.den != '0 && prep_reg.den >= thr_reg)
        else $error("divisor below threshold passed as regular");

    // Stall freezes the pipeline head and tail
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(prep_valid_reg) && $stable(stg[DIV_STEPS].valid))
        else $error("pipeline moved during stall");

endmodule

// ===== tb/sv/cramer_3x3_linear_solver_checker.sv =====
// Checker for the 3x3 solver: watches both channels, predicts solutions and compares.
`timescale 1ns / 1ps

module cramer_3x3_linear_solver_checker
    import crs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    crs_in_if             in_ch,
    crs_out_if            out_ch,
    input  logic          wr_en,
    input  logic [MAG_W-1:0] wr_data,
    output int            fail_count,
    output int            pending
);

    typedef struct {
        sol_t x0;
        sol_t x1;
        sol_t x2;
        logic singular;
    } solution_t;

    solution_t     solution_queue[$];
    logic [MAG_W-1:0] threshold;

    // Six-term determinant of a [row][col] matrix
    function automatic longint det3(input longint a[3][3]);
        return a[0][0] * a[1][1] * a[2][2] + a[0][1] * a[1][2] * a[2][0]
             + a[0][2] * a[1][0] * a[2][1] - a[0][2] * a[1][1] * a[2][0]
             - a[0][1] * a[1][0] * a[2][2] - a[0][0] * a[1][2] * a[2][1];
    endfunction

    // Q24.24 ratio to Q16.16, truncated toward zero, saturated
    function automatic sol_t ratio_q16(input longint num, input longint den);
        logic            neg;
        longint unsigned n;
        longint unsigned q;
        longint unsigned m;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        m = (den < 0) ? -den : den;
        q = (n << 16) / m;
        if (neg)
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            return sol_t'(-q);
        end
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return sol_t'(q);
    endfunction

    function automatic solution_t solve_system(input q88_t e[12], input logic [MAG_W-1:0] thr);
        longint    a[3][3];
        longint    t[3][3];
        longint    b[3];
        longint    d;
        longint unsigned dm;
        solution_t s;
        sol_t      x[3];
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                a[r][c] = e[c * 3 + r];
        for (int r = 0; r < 3; r++)
            b[r] = e[9 + r];
        d = det3(a);
        dm = (d < 0) ? -d : d;
        if (d == 0 || dm < thr)
        begin
            s = '{0, 0, 0, 1'b1};
            return s;
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    t[r][c] = (c == k) ? b[r] : a[r][c];
            x[k] = ratio_q16(det3(t), d);
        end
        s = '{x[0], x[1], x[2], 1'b0};
        return s;
    endfunction

    assign pending = solution_queue.size();

    // Track register, predict on each request, compare each result
    always @(posedge clk or negedge rst_n)
    begin
        q88_t      e[12];
        solution_t want;
        if (!rst_n)
        begin
            threshold <= 1;
            fail_count <= 0;
            solution_queue.delete();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (solution_queue.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result x0=%h", out_ch.sol_x0);
                end
                else
                begin
                    want = solution_queue.pop_front();
                    if (want.x0 !== out_ch.sol_x0 || want.x1 !== out_ch.sol_x1 ||
                        want.x2 !== out_ch.sol_x2 || want.singular !== out_ch.singular)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: want %h %h %h s%b got %h %h %h s%b",
                                     want.x0, want.x1, want.x2, want.singular,
                                     out_ch.sol_x0, out_ch.sol_x1, out_ch.sol_x2,
                                     out_ch.singular);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                e = '{in_ch.col0_row0, in_ch.col0_row1, in_ch.col0_row2,
                      in_ch.col1_row0, in_ch.col1_row1, in_ch.col1_row2,
                      in_ch.col2_row0, in_ch.col2_row1, in_ch.col2_row2,
                      in_ch.rhs_row0, in_ch.rhs_row1, in_ch.rhs_row2};
                solution_queue.push_back(solve_system(e, threshold));
            end
            if (wr_en)
                threshold <= wr_data;
        end
    end

endmodule

// ===== tb/sv/cramer_3x3_linear_solver_test.sv =====
// Top of the 3x3 solver testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module cramer_3x3_linear_solver_test;
    import crs_pkg::*;

    localparam int LATENCY   = 38;
    localparam int IDLE_MAX  = 17;
    localparam int STALL_LEN = 800;
    localparam int WATCHDOG  = 5000;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [MAG_W-1:0] wr_data;
    int   fail_count;
    int   pending;
    int   quiet_cycles;
    bit   stall_done;
    bit   hold_long;

    crs_in_if  in_ch ();
    crs_out_if out_ch ();

    cramer_3x3_linear_solver dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    cramer_3x3_linear_solver_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .wr_en      (wr_en),
        .wr_data    (wr_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Count cycles with no handshake; end the run on a hang
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("cramer_3x3_linear_solver_test: FAIL");
            $finish;
        end
    end

    // Receiver: random hold-offs, plus one long stall on request
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        stall_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long && !stall_done)
            begin
                out_ch.ready <= 1'b0;
                repeat (STALL_LEN) @(negedge clk);
                stall_done = 1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
            if (hold_long && !stall_done)
                gap = 0;
            if (gap > 0 && $urandom_range(0, 1))
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    // Drop valid only for an idle gap so back-to-back requests keep it high
    task automatic send_system(input q88_t e[12], input int gap);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.col0_row0 <= e[0];
        in_ch.col0_row1 <= e[1];
        in_ch.col0_row2 <= e[2];
        in_ch.col1_row0 <= e[3];
        in_ch.col1_row1 <= e[4];
        in_ch.col1_row2 <= e[5];
        in_ch.col2_row0 <= e[6];
        in_ch.col2_row1 <= e[7];
        in_ch.col2_row2 <= e[8];
        in_ch.rhs_row0  <= e[9];
        in_ch.rhs_row1  <= e[10];
        in_ch.rhs_row2  <= e[11];
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Draw a system: full range, zero determinant, small entries, or diagonally dominant
    function automatic void random_system(output q88_t e[12]);
        int kind;
        kind = $urandom_range(0, 5);
        for (int i = 0; i < 12; i++)
        begin
            case (kind)
                0, 1:    e[i] = q88_t'($urandom);
                2:       e[i] = q88_t'($signed($urandom_range(0, 1023)) - 512);
                3:       e[i] = q88_t'($signed($urandom_range(0, 15)) - 8);
                default: e[i] = (i < 9 && i % 4 != 0) ? q88_t'($signed($urandom_range(0, 7)) - 4)
                                                      : q88_t'($urandom);
            endcase
        end
        if (kind == 1)
            for (int r = 0; r < 3; r++)
                e[6 + r] = e[r];           // repeated column: zero determinant
    endfunction

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [MAG_W-1:0] value);
        @(negedge clk);
        wr_en   <= 1'b1;
        wr_data <= value;
        @(negedge clk);
        wr_en   <= 1'b0;
    endtask

    initial
    begin
        q88_t e[12];
        logic [MAG_W-1:0] thresholds[5];
        int   phase_items;
        thresholds = '{48'd0, 48'hFFFF_FFFF_FFFF, 48'h1_0000_0000, 48'd1 << 24, 48'd1};
        rst_n        = 1'b0;
        wr_en        = 1'b0;
        wr_data      = '0;
        hold_long    = 0;
        quiet_cycles = 0;
        in_ch.valid  = 1'b0;
        {in_ch.col0_row0, in_ch.col0_row1, in_ch.col0_row2, in_ch.col1_row0,
         in_ch.col1_row1, in_ch.col1_row2, in_ch.col2_row0, in_ch.col2_row1,
         in_ch.col2_row2, in_ch.rhs_row0, in_ch.rhs_row1, in_ch.rhs_row2} = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: identity, extremes, zero determinant, saturation, tiny det
        e = '{16'h0100, 0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100, 16'h7FFF, 16'h8000, 16'h0001};
        send_system(e, 0);
        e = '{16'h7FFF, 0, 0, 0, 16'h7FFF, 0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF};
        send_system(e, 0);
        e = '{16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000, 16'h8000, 16'h7FFF, 16'h0100};
        send_system(e, 1);
        e = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
              16'h7FFF, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h7FFF};
        send_system(e, 0);
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h1234, 0, 0};
        send_system(e, 2);
        e = '{1, 0, 0, 0, 1, 0, 0, 0, 1, 16'h7FFF, 16'h8000, 16'h0100};
        send_system(e, 0);
        e = '{1, 0, 0, 0, 1, 0, 0, 0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000};
        send_system(e, 0);
        e = '{16'h0100, 16'h0200, 16'h0300, 16'h0200, 16'h0400, 16'h0600, 1, 2, 3,
              16'h0100, 16'h0100, 16'h0100};
        send_system(e, 0);
        e = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        send_system(e, 0);
        wait_drained();

        // Random phases, one per threshold setting; first phase adds the long stall
        for (int p = 0; p < 5; p++)
        begin
            write_threshold(thresholds[p]);
            phase_items = (p == 4) ? 500 : 210;
            for (int i = 0; i < phase_items; i++)
            begin
                if (p == 0 && i == 20)
                    hold_long = 1;
                random_system(e);
                send_system(e, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX));
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("cramer_3x3_linear_solver_test: PASS");
        else
            $display("cramer_3x3_linear_solver_test: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/crs_pkg.sv
src/crs_if.sv
src/crs_det.sv
src/crs_div_step.sv
src/cramer_3x3_linear_solver.sv
tb/sv/cramer_3x3_linear_solver_checker.sv
tb/sv/cramer_3x3_linear_solver_test.sv
